>>> hdl/assert_macros.svh
// Assertion macros used by the checker module of the divider.
// No dependencies; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/idr_pkg.sv
// Package of the shift-subtract divider: widths, controller states and the
// command/status groups between controller and datapath. No dependencies.
`default_nettype none

package idr_pkg;

  // Port width of the operand and result fields.
  localparam int IDR_IO_W       = 64;
  // Default internal division width.
  localparam int IDR_DATA_WIDTH = 64;

  // Controller states.
  typedef enum logic [1:0] {
    IDR_IDLE,
    IDR_PREP,
    IDR_ITER,
    IDR_FIX
  } idr_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;   // capture operands of an accepted item
    logic prep;   // take magnitudes, clear partial remainder
    logic iter;   // one restoring-division step
    logic fix;    // sign correction and result registers
  } idr_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_zero;  // captured divisor is zero
  } idr_stat_t;

endpackage

`default_nettype wire

>>> hdl/idr_ctrl.sv
// Controller of the divider: state machine and step counter.
// Depends on idr_pkg; drives idr_dpath through idr_cmd_t.
`default_nettype none

module idr_ctrl #(
  parameter int DATA_WIDTH = idr_pkg::IDR_DATA_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire idr_pkg::idr_stat_t stat,
  output idr_pkg::idr_cmd_t     cmd,
  output logic                  busy
);
  import idr_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  idr_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDR_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      IDR_IDLE: if (start) state_nxt = IDR_PREP;
      IDR_PREP: state_nxt = stat.div_zero ? IDR_FIX : IDR_ITER;
      IDR_ITER: if (cnt_r == '0) state_nxt = IDR_FIX;
      IDR_FIX:  state_nxt = IDR_IDLE;
      default:  state_nxt = IDR_IDLE;
    endcase
  end

  // Step counter: loaded in PREP, counts quotient bits down in ITER
  always_comb begin
    cnt_nxt = cnt_r;
    case (state_r)
      IDR_PREP: cnt_nxt = CNT_LAST;
      IDR_ITER: cnt_nxt = cnt_r - CNT_W'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      IDR_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      IDR_PREP: cmd.prep = 1'b1;
      IDR_ITER: cmd.iter = 1'b1;
      IDR_FIX:  cmd.fix  = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/idr_dpath.sv
// Datapath of the divider: operand registers, sign handling, one
// restoring-division step per cycle, result registers. Depends on idr_pkg.
`default_nettype none

module idr_dpath #(
  parameter int DATA_WIDTH = idr_pkg::IDR_DATA_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire idr_pkg::idr_cmd_t             cmd,
  output idr_pkg::idr_stat_t                 stat,
  input  wire logic                          in_cmd,
  input  wire logic [idr_pkg::IDR_IO_W-1:0]  in_dividend,
  input  wire logic [idr_pkg::IDR_IO_W-1:0]  in_divisor,
  output logic                               out_valid,
  output logic [idr_pkg::IDR_IO_W-1:0]       out_quotient,
  output logic [idr_pkg::IDR_IO_W-1:0]       out_remainder,
  output logic                               out_divide_by_zero
);
  import idr_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] ZERO_W = '0;

  // Captured operands
  logic [W-1:0] op_a_r, op_b_r;
  logic         sgn_r;
  // Working registers: n_r shifts the dividend out and the quotient in
  logic [W-1:0] n_r, d_r, rem_r;
  logic         neg_q_r, neg_r_r, dz_r;
  // Result registers
  logic [IDR_IO_W-1:0] q_out_r, r_out_r;
  logic                dz_out_r, valid_r;

  logic         a_neg, b_neg;
  logic [W+1:0] trial;
  logic         ge;
  logic [W-1:0] q_fix, r_fix;

  assign stat.div_zero = (op_b_r == ZERO_W);

  // Operand signs and trial subtraction of one step
  assign a_neg = sgn_r & op_a_r[W-1];
  assign b_neg = sgn_r & op_b_r[W-1];
  assign trial = {1'b0, rem_r, n_r[W-1]} - {2'b00, d_r};
  assign ge    = ~trial[W+1];

  // Sign correction of the final quotient and remainder
  assign q_fix = neg_q_r ? (ZERO_W - n_r) : n_r;
  assign r_fix = neg_r_r ? (ZERO_W - rem_r) : rem_r;

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_a_r <= in_dividend[W-1:0];
      op_b_r <= in_divisor[W-1:0];
      sgn_r  <= in_cmd;
    end
    if (cmd.prep) begin
      n_r     <= a_neg ? (ZERO_W - op_a_r) : op_a_r;
      d_r     <= b_neg ? (ZERO_W - op_b_r) : op_b_r;
      rem_r   <= ZERO_W;
      neg_q_r <= a_neg ^ b_neg;
      neg_r_r <= a_neg;
      dz_r    <= stat.div_zero;
    end
    if (cmd.iter) begin
      n_r   <= {n_r[W-2:0], ge};
      rem_r <= ge ? trial[W-1:0] : {rem_r[W-2:0], n_r[W-1]};
    end
    if (cmd.fix) begin
      q_out_r  <= dz_r ? '0 : IDR_IO_W'(q_fix);
      r_out_r  <= dz_r ? IDR_IO_W'(op_a_r) : IDR_IO_W'(r_fix);
      dz_out_r <= dz_r;
    end
  end

  // Result strobe: registered, high in the cycle after the fix-up step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.fix;
    end
  end

  assign out_valid          = valid_r;
  assign out_quotient       = q_out_r;
  assign out_remainder      = r_out_r;
  assign out_divide_by_zero = dz_out_r;

endmodule

`default_nettype wire

>>> hdl/int64_divide_remainder.sv
// Top level of the shift-subtract integer divider: controller plus datapath.
// Depends on idr_pkg, idr_ctrl and idr_dpath.
//
// Use:
//   An item (in_cmd, in_dividend, in_divisor) is accepted at a rising edge
//   with start high and busy low. in_cmd 0 divides unsigned, 1 divides
//   two's complement; only the low DATA_WIDTH operand bits are used.
//   One result per item: out_quotient, out_remainder, out_divide_by_zero,
//   shown for exactly one cycle while out_valid is high. Bits above
//   DATA_WIDTH read zero. A zero divisor gives quotient 0, the dividend as
//   remainder and the flag set.
// Timing:
//   A sign/magnitude step, DATA_WIDTH restoring steps (one quotient bit
//   per cycle through a single subtractor), then a fix-up step. out_valid
//   is registered from the fix-up step; busy drops as out_valid rises, so
//   a new item is taken only once the last one's result is shown. A zero
//   divisor skips the restoring steps and goes straight to the fix-up step.
// Reset:
//   Synchronous, active low rst_n; returns to idle, no result pending.
//   The receiver cannot stall: each result is taken in its strobe cycle.
`default_nettype none

module int64_divide_remainder #(
  parameter int DATA_WIDTH = idr_pkg::IDR_DATA_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_cmd,
  input  wire logic [idr_pkg::IDR_IO_W-1:0]  in_dividend,
  input  wire logic [idr_pkg::IDR_IO_W-1:0]  in_divisor,
  output logic                               out_valid,
  output logic [idr_pkg::IDR_IO_W-1:0]       out_quotient,
  output logic [idr_pkg::IDR_IO_W-1:0]       out_remainder,
  output logic                               out_divide_by_zero
);
  import idr_pkg::*;

  idr_cmd_t  cmd;
  idr_stat_t stat;

  // Sequencer
  idr_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Arithmetic
  idr_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_cmd             (in_cmd),
    .in_dividend        (in_dividend),
    .in_divisor         (in_divisor),
    .out_valid          (out_valid),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

`default_nettype wire

>>> hdl/idr_checker.sv
// Port-level checker of the divider and its bind to the top level.
// Depends on idr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module idr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic [idr_pkg::IDR_IO_W-1:0]  out_quotient,
  input wire logic                          out_divide_by_zero
);
  import idr_pkg::*;

  // An accepted item makes the block busy
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // The end of the busy period is the result strobe
  `ASSERT_SAME(a_done_strobe, clk, rst_n, $fell(busy), out_valid)
  // One result per item: the strobe always drops again after it rises
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // A zero divisor gives a zero quotient
  `ASSERT_SAME(a_dz_quot, clk, rst_n, out_valid && out_divide_by_zero,
               out_quotient == '0)

endmodule

bind int64_divide_remainder idr_checker u_idr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_quotient       (out_quotient),
  .out_divide_by_zero (out_divide_by_zero)
);

`default_nettype wire
